### sv/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared definitions for the point-in-polygon test unit
// Defaults, fixed field widths, operation codes, sequencer states and the
// control records that pass between the sequencer and the edge unit.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned CoordBitsDef   = 16;
  localparam int unsigned VidxW          = 6;
  localparam int unsigned VcntW          = 7;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } pip_state_e;

  // Tag that travels with a vertex read out of the store.
  typedef struct packed {
    logic vld;
    logic first;
  } pip_rd_tag_t;

  // Per-edge verdict and pipeline occupancy from the edge unit.
  typedef struct packed {
    logic vld;
    logic busy;
    logic on_seg;
    logic cross_hit;
  } pip_edge_res_t;

endpackage

### sv/pip_vertex_mem.sv
// ----------------------------------------------------------------------------
// pip_vertex_mem: polygon vertex store
// One write port and one registered read port; each word holds {y, x}.
// ----------------------------------------------------------------------------
module pip_vertex_mem #(
  parameter int unsigned DEPTH  = pip_pkg::MaxVerticesDef,
  parameter int unsigned DATA_W = 2 * pip_pkg::CoordBitsDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/pip_edge_unit.sv
// ----------------------------------------------------------------------------
// pip_edge_unit: shared edge evaluation pipeline
// Takes one vertex per cycle, pairs it with the previous one to form an edge
// and decides in three stages whether the point lies on that edge and whether
// a ray from the point crosses it.
// ----------------------------------------------------------------------------
module pip_edge_unit #(
  parameter int unsigned COORD_BITS = pip_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pip_pkg::pip_rd_tag_t         tag_i,
  input  logic signed [COORD_BITS-1:0] vx_i,
  input  logic signed [COORD_BITS-1:0] vy_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  output pip_pkg::pip_edge_res_t       res_o
);

  import pip_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;

  logic signed [COORD_BITS-1:0] bx_q, by_q;

  logic                 s1_vld_q;
  logic signed [DW-1:0] dxba_q, dyba_q, pxa_q, pya_q, pxb_q, pyb_q;
  logic                 s1_strad_q, s1_dypos_q;

  logic                 s2_vld_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic                 s2_strad_q, s2_dypos_q;

  logic                 s3_vld_q, s3_on_q, s3_hit_q;

  logic signed [SW-1:0] cross_w, dot_w;

  // Previous vertex is the second endpoint of the edge.
  always_ff @(posedge clk_i) begin
    if (tag_i.vld) begin
      bx_q <= vx_i;
      by_q <= vy_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= tag_i.vld && !tag_i.first;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dxba_q     <= DW'(bx_q) - DW'(vx_i);
    dyba_q     <= DW'(by_q) - DW'(vy_i);
    pxa_q      <= DW'(px_i) - DW'(vx_i);
    pya_q      <= DW'(py_i) - DW'(vy_i);
    pxb_q      <= DW'(px_i) - DW'(bx_q);
    pyb_q      <= DW'(py_i) - DW'(by_q);
    s1_strad_q <= (vy_i > py_i) != (by_q > py_i);
    s1_dypos_q <= by_q > vy_i;
  end

  always_ff @(posedge clk_i) begin
    p1_q       <= PW'(dxba_q) * PW'(pya_q);
    p2_q       <= PW'(dyba_q) * PW'(pxa_q);
    p3_q       <= PW'(pxa_q) * PW'(pxb_q);
    p4_q       <= PW'(pya_q) * PW'(pyb_q);
    s2_strad_q <= s1_strad_q;
    s2_dypos_q <= s1_dypos_q;
  end

  assign cross_w = SW'(p1_q) - SW'(p2_q);
  assign dot_w   = SW'(p3_q) + SW'(p4_q);

  // The crossing compare uses the cross product of edge and point, so its sign test flips with the edge's y direction.
  always_ff @(posedge clk_i) begin
    s3_on_q  <= (cross_w == '0) && (dot_w <= 0);
    s3_hit_q <= s2_strad_q && (s2_dypos_q ? (cross_w > 0) : (cross_w < 0));
  end

  always_comb begin
    res_o.vld       = s3_vld_q;
    res_o.busy      = s1_vld_q || s2_vld_q || s3_vld_q;
    res_o.on_seg    = s3_on_q;
    res_o.cross_hit = s3_hit_q;
  end

endmodule

### sv/point_in_polygon_test_unit.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit: point-in-polygon test over a stored polygon
// A vertex write goes into the vertex store as it is taken; a query walks its n
// vertices one edge per cycle through the vertex store read port and the
// three-stage edge unit. With no vertices the query skips the walk and goes
// straight to the done state.
// Throughput: one request at a time; the next request is taken while a result
// waits at the output. Reset clears the vertex count and all control state;
// vertex store contents are undefined until written.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit #(
  parameter int unsigned MAX_VERTICES = pip_pkg::MaxVerticesDef,
  parameter int unsigned COORD_BITS   = pip_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pip_pkg::VcntW-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [pip_pkg::VidxW-1:0]      vertex_index_i,
  input  logic signed [COORD_BITS-1:0]   vertex_x_i,
  input  logic signed [COORD_BITS-1:0]   vertex_y_i,
  input  logic signed [COORD_BITS-1:0]   point_x_i,
  input  logic signed [COORD_BITS-1:0]   point_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           inside_res_o
);

  import pip_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned NW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned IXW = ((AW > VidxW) ? AW : VidxW) + 1;
  localparam int unsigned CW  = (NW > VcntW) ? NW : VcntW;

  pip_state_e state_q, state_d;

  logic [VcntW-1:0] cnt_q;
  logic [CW-1:0]    cnt_ext;
  logic [NW-1:0]    n_sat;
  logic [NW-1:0]    rd_cnt_q, rd_cnt_d;
  logic [NW-1:0]    rd_idx;
  logic [IXW-1:0]   idx_ext;

  logic accept, acc_query, acc_write, out_free;
  logic mem_we, rd_en;

  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [2*COORD_BITS-1:0]      rdata;
  pip_rd_tag_t                  rtag_q;
  pip_edge_res_t                eres;

  logic on_any_q, par_q, final_res;
  logic out_valid_q, inside_q;

  assign accept    = in_valid_i && !in_stall_o;
  assign acc_query = accept && (op_i == OpQuery);
  assign acc_write = accept && (op_i == OpWrite);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign cnt_ext = CW'(cnt_q);
  assign n_sat   = (cnt_ext > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : cnt_ext[NW-1:0];

  assign idx_ext = IXW'(vertex_index_i);
  assign mem_we  = acc_write && (idx_ext < IXW'(MAX_VERTICES));

  // The walk reads the last vertex first so that the closing edge back to vertex 0 is tested too.
  assign rd_idx = (rd_cnt_q == '0) ? (n_sat - NW'(1)) : (rd_cnt_q - NW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_query) begin
          state_d = (n_sat == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        if (rd_cnt_q == n_sat) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rtag_q.vld && !eres.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    rd_cnt_d   = rd_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        rd_cnt_d   = '0;
      end
      ST_READ: begin
        rd_en    = 1'b1;
        rd_cnt_d = (rd_cnt_q == n_sat) ? rd_cnt_q : rd_cnt_q + NW'(1);
      end
      ST_DRAIN, ST_DONE: begin
        rd_cnt_d = rd_cnt_q;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_cnt_q <= '0;
      rtag_q   <= '0;
      on_any_q <= 1'b0;
      par_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_cnt_q     <= rd_cnt_d;
      rtag_q.vld   <= rd_en;
      rtag_q.first <= rd_cnt_q == '0;
      if (acc_query) begin
        on_any_q <= 1'b0;
        par_q    <= 1'b0;
      end else if (eres.vld) begin
        on_any_q <= on_any_q || eres.on_seg;
        par_q    <= par_q ^ eres.cross_hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_query) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
  end

  pip_vertex_mem #(
    .DEPTH  (MAX_VERTICES),
    .DATA_W (2 * COORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i ({vertex_y_i, vertex_x_i}),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (rdata)
  );

  pip_edge_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (rtag_q),
    .vx_i   (rdata[COORD_BITS-1:0]),
    .vy_i   (rdata[2*COORD_BITS-1:COORD_BITS]),
    .px_i   (px_q),
    .py_i   (py_q),
    .res_o  (eres)
  );

  // Fewer than three vertices leave only the boundary test.
  assign final_res = on_any_q || ((n_sat >= NW'(3)) && par_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      inside_q <= final_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  a_empty_query_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_query && (n_sat == '0) |=> state_q == ST_DONE)
    else $error("query on an empty polygon did not finish at once");

  a_rd_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_cnt_q <= n_sat)
    else $error("vertex walk ran past the vertex count");

  a_edge_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eres.vld |-> (state_q == ST_READ || state_q == ST_DRAIN))
    else $error("edge verdict arrived outside a walk");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result issued without a finished query");

endmodule
